// File: hw/rtl/acd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affinity chunk dispenser package
// Shared widths, codes, state encoding and the layouts of the per-thread
// entry and of the result word.
// ----------------------------------------------------------------------------
package acd_pkg;

    localparam int THREADS_DEFAULT = 8;
    localparam int DATA_W          = 16;
    localparam int TID_W           = 3;
    localparam int SEG_W           = 3;
    localparam int RECIP_SHIFT     = 22;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 40;

    localparam logic [DATA_W-1:0] TOTAL_RESET = 16'd729;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic [SEG_W-1:0]  segment;
        logic [DATA_W-1:0] left_count;
        logic [DATA_W-1:0] next_index;
    } entry_t;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_id;
        logic [TID_W-1:0]  victim_thread;
        logic              stolen;
        logic [DATA_W-1:0] chunk_end;
        logic [DATA_W-1:0] chunk_start;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OWN,
        ST_SCAN,
        ST_STEAL,
        ST_CHUNK,
        ST_EMPTY,
        ST_START_DIV,
        ST_SWEEP
    } state_t;

endpackage

// File: hw/rtl/acd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divide by thread count
// Two-stage unsigned division of a 16-bit value by the constant THREADS,
// using a reciprocal multiplication followed by a single correction step.
// ----------------------------------------------------------------------------
module acd_div #(
    parameter int THREADS = acd_pkg::THREADS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [acd_pkg::DATA_W-1:0] dividend,
    output logic                       valid,
    output logic [acd_pkg::DATA_W-1:0] quotient
);

    localparam int RW = acd_pkg::RECIP_SHIFT + 1;
    localparam int PW = acd_pkg::DATA_W + RW;
    localparam int DW = 7;
    localparam logic [RW-1:0] RECIP   = RW'((1 << acd_pkg::RECIP_SHIFT) / THREADS);
    localparam logic [DW-1:0] DIVISOR = DW'(THREADS);

    logic                       stage1_reg;
    logic                       valid_reg;
    logic [PW-1:0]              prod_reg;
    logic [acd_pkg::DATA_W-1:0] x_reg;
    logic [acd_pkg::DATA_W-1:0] q_reg;

    logic [acd_pkg::DATA_W-1:0] q_est;
    logic [RW-1:0]              back_prod;
    logic [RW-1:0]              remainder;
    logic [acd_pkg::DATA_W-1:0] q_next;

    always_comb begin
        q_est     = prod_reg[acd_pkg::RECIP_SHIFT +: acd_pkg::DATA_W];
        back_prod = RW'(q_est) * RW'(DIVISOR);
        remainder = RW'(x_reg) - back_prod;
        q_next    = q_est + acd_pkg::DATA_W'(remainder >= RW'(DIVISOR));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            stage1_reg <= start;
            if (start) begin
                valid_reg <= 1'b0;
            end else if (stage1_reg) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PW'(dividend) * PW'(RECIP);
            x_reg    <= dividend;
        end
        if (stage1_reg) begin
            q_reg <= q_next;
        end
    end

    assign valid    = valid_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/acd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-thread state store
// One synchronous memory of THREADS entries with registered read data.
// Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module acd_store #(
    parameter int THREADS = acd_pkg::THREADS_DEFAULT,
    parameter int AW      = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  acd_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output acd_pkg::entry_t rd_data
);

    acd_pkg::entry_t    mem_reg [THREADS];
    acd_pkg::entry_t    rd_data_reg;
    logic [THREADS-1:0] valid_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/acd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk dispenser sequencer
// Accepts start and request transfers, reads and updates the per-thread
// store, scans for the richest thread when stealing, and holds the result.
// ----------------------------------------------------------------------------
module acd_ctrl #(
    parameter int THREADS = acd_pkg::THREADS_DEFAULT,
    parameter int AW      = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_op,
    input  logic [acd_pkg::TID_W-1:0]  s_tid,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output acd_pkg::result_t           m_result,
    output logic                       m_done,
    input  logic [acd_pkg::DATA_W-1:0] total_iterations,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output acd_pkg::entry_t            wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  acd_pkg::entry_t            rd_data,
    output logic                       div_start,
    output logic [acd_pkg::DATA_W-1:0] div_dividend,
    input  logic                       div_valid,
    input  logic [acd_pkg::DATA_W-1:0] div_quotient
);

    localparam int CW = $clog2(THREADS + 1);
    localparam int DW = acd_pkg::DATA_W;

    acd_pkg::state_t            state_reg, state_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    acd_pkg::result_t           m_result_reg, m_result_next;
    logic                       m_done_reg, m_done_next;
    logic [acd_pkg::TID_W-1:0]  tid_reg, tid_next;
    logic [CW-1:0]              scan_cnt_reg, scan_cnt_next;
    logic [DW-1:0]              best_reg, best_next;
    logic [AW-1:0]              bt_reg, bt_next;
    acd_pkg::entry_t            best_entry_reg, best_entry_next;
    acd_pkg::entry_t            own_reg, own_next;
    logic                       stolen_reg, stolen_next;
    logic [acd_pkg::TID_W-1:0]  victim_reg, victim_next;
    logic                       done_reg, done_next;
    logic [DW-1:0]              seg_reg, seg_next;
    logic [DW-1:0]              base_reg, base_next;
    logic [AW-1:0]              sweep_cnt_reg, sweep_cnt_next;

    logic          out_free;
    logic [CW-1:0] scan_prev;
    logic [DW-1:0] chunk;
    logic [DW-1:0] chunk_end;

    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_result_next   = m_result_reg;
        m_done_next     = m_done_reg;
        tid_next        = tid_reg;
        scan_cnt_next   = scan_cnt_reg;
        best_next       = best_reg;
        bt_next         = bt_reg;
        best_entry_next = best_entry_reg;
        own_next        = own_reg;
        stolen_next     = stolen_reg;
        victim_next     = victim_reg;
        done_next       = done_reg;
        seg_next        = seg_reg;
        base_next       = base_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        s_tready        = 1'b0;

        out_free  = !m_tvalid_reg || m_tready;
        scan_prev = scan_cnt_reg - CW'(1);
        chunk     = (div_quotient == '0) ? DW'(1) : div_quotient;
        chunk_end = own_reg.next_index + chunk;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            acd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    tid_next = s_tid;
                    case (s_op)
                        acd_pkg::OP_START: begin
                            div_start    = 1'b1;
                            div_dividend = total_iterations;
                            state_next   = acd_pkg::ST_START_DIV;
                        end
                        acd_pkg::OP_REQUEST: begin
                            if (int'(s_tid) >= THREADS) begin
                                done_next  = 1'b0;
                                state_next = acd_pkg::ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(s_tid);
                                state_next = acd_pkg::ST_OWN;
                            end
                        end
                        default: begin
                            state_next = acd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            acd_pkg::ST_OWN: begin
                if (rd_data.left_count != '0) begin
                    own_next     = rd_data;
                    stolen_next  = 1'b0;
                    victim_next  = '0;
                    div_start    = 1'b1;
                    div_dividend = rd_data.left_count;
                    state_next   = acd_pkg::ST_CHUNK;
                end else begin
                    scan_cnt_next   = '0;
                    best_next       = '0;
                    bt_next         = '0;
                    best_entry_next = '0;
                    state_next      = acd_pkg::ST_SCAN;
                end
            end
            acd_pkg::ST_SCAN: begin
                if (scan_cnt_reg != CW'(THREADS)) begin
                    rd_en   = 1'b1;
                    rd_addr = scan_cnt_reg[AW-1:0];
                end
                if (scan_cnt_reg != '0 && rd_data.left_count > best_reg) begin
                    best_next       = rd_data.left_count;
                    bt_next         = scan_prev[AW-1:0];
                    best_entry_next = rd_data;
                end
                if (scan_cnt_reg == CW'(THREADS)) begin
                    state_next = acd_pkg::ST_STEAL;
                end else begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
            end
            acd_pkg::ST_STEAL: begin
                if (best_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = acd_pkg::ST_EMPTY;
                end else begin
                    wr_en              = 1'b1;
                    wr_addr            = bt_reg;
                    wr_data            = best_entry_reg;
                    wr_data.left_count = '0;
                    own_next           = best_entry_reg;
                    stolen_next        = 1'b1;
                    victim_next        = acd_pkg::TID_W'(bt_reg);
                    div_start          = 1'b1;
                    div_dividend       = best_entry_reg.left_count;
                    state_next         = acd_pkg::ST_CHUNK;
                end
            end
            acd_pkg::ST_CHUNK: begin
                if (div_valid && out_free) begin
                    wr_en                       = 1'b1;
                    wr_addr                     = AW'(tid_reg);
                    wr_data.next_index          = chunk_end;
                    wr_data.left_count          = own_reg.left_count - chunk;
                    wr_data.segment             = own_reg.segment;
                    m_tvalid_next               = 1'b1;
                    m_done_next                 = 1'b0;
                    m_result_next.chunk_start   = own_reg.next_index;
                    m_result_next.chunk_end     = chunk_end;
                    m_result_next.stolen        = stolen_reg;
                    m_result_next.victim_thread = victim_reg;
                    m_result_next.segment_id    = own_reg.segment;
                    state_next                  = acd_pkg::ST_IDLE;
                end
            end
            acd_pkg::ST_EMPTY: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_done_next   = done_reg;
                    m_result_next = '0;
                    state_next    = acd_pkg::ST_IDLE;
                end
            end
            acd_pkg::ST_START_DIV: begin
                if (div_valid) begin
                    seg_next       = div_quotient;
                    base_next      = '0;
                    sweep_cnt_next = '0;
                    state_next     = acd_pkg::ST_SWEEP;
                end
            end
            acd_pkg::ST_SWEEP: begin
                wr_en              = 1'b1;
                wr_addr            = sweep_cnt_reg;
                wr_data.next_index = base_reg;
                wr_data.left_count = seg_reg;
                wr_data.segment    = acd_pkg::SEG_W'(sweep_cnt_reg);
                base_next          = base_reg + seg_reg;
                if (sweep_cnt_reg == AW'(THREADS - 1)) begin
                    wr_data.left_count = total_iterations - base_reg;
                    state_next         = acd_pkg::ST_IDLE;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + AW'(1);
                end
            end
            default: begin
                state_next = acd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= acd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg   <= m_result_next;
        m_done_reg     <= m_done_next;
        tid_reg        <= tid_next;
        scan_cnt_reg   <= scan_cnt_next;
        best_reg       <= best_next;
        bt_reg         <= bt_next;
        best_entry_reg <= best_entry_next;
        own_reg        <= own_next;
        stolen_reg     <= stolen_next;
        victim_reg     <= victim_next;
        done_reg       <= done_next;
        seg_reg        <= seg_next;
        base_reg       <= base_next;
        sweep_cnt_reg  <= sweep_cnt_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_result = m_result_reg;
    assign m_done   = m_done_reg;

endmodule

// File: hw/rtl/affinity_chunk_dispenser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affinity chunk dispenser core
// A request served from the thread's own work reads its entry from the
// state memory, divides the remaining count by THREADS and registers the
// result; a request that steals first scans every entry of the state memory
// once. A start divides the total by THREADS and writes one entry per thread.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken.
// Reset clears control state and marks every memory entry as zero; the
// iteration count register returns to 729.
// ----------------------------------------------------------------------------
module affinity_chunk_dispenser_core #(
    parameter int THREADS = acd_pkg::THREADS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] thread_id
    input  logic [acd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] chunk_start, [31:16] chunk_end, [32] stolen,
    // [35:33] victim_thread, [38:36] segment_id
    output logic [acd_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] done_res
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [acd_pkg::DATA_W-1:0]    cfg_data
);

    localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;

    logic [acd_pkg::DATA_W-1:0] total_reg;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    acd_pkg::entry_t            wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    acd_pkg::entry_t            rd_data;
    logic                       div_start;
    logic [acd_pkg::DATA_W-1:0] div_dividend;
    logic                       div_valid;
    logic [acd_pkg::DATA_W-1:0] div_quotient;
    acd_pkg::result_t           m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= acd_pkg::TOTAL_RESET;
        end else if (cfg_valid) begin
            total_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    acd_store #(
        .THREADS (THREADS),
        .AW      (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    acd_div #(
        .THREADS (THREADS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .valid    (div_valid),
        .quotient (div_quotient)
    );

    acd_ctrl #(
        .THREADS (THREADS),
        .AW      (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_op             (s_tuser),
        .s_tid            (s_tdata[acd_pkg::TID_W-1:0]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_result         (m_result),
        .m_done           (m_tuser),
        .total_iterations (total_reg),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .div_start        (div_start),
        .div_dividend     (div_dividend),
        .div_valid        (div_valid),
        .div_quotient     (div_quotient)
    );

    assign m_tdata = {1'b0, m_result};

endmodule
